// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms, sampled on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define BSPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define BSPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/bspr_pkg.sv
// ----------------------------------------------------------------------------
// bspr_pkg
// Types, sizes and codes shared by the pattern remover core and its
// register block.
// ----------------------------------------------------------------------------
package bspr_pkg;

  // Window depth and derived widths
  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned FILL_W      = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Fixed field widths
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PAT_W     = 8 * PAT_BYTES;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 64;

  // Register map, 8-byte stride
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LEN    = 2'd1,
    REG_PAT_LO = 2'd2,
    REG_PAT_HI = 2'd3
  } reg_idx_e;

  // Removal modes; the unused code passes data through
  typedef enum logic [1:0] {
    MODE_PREFIX = 2'd0,
    MODE_SUFFIX = 2'd1,
    MODE_ALL    = 2'd2,
    MODE_PASS   = 2'd3
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_DROP,
    S_POP1,
    S_EMIT,
    S_SUFFIX
  } state_e;

  // What the current scan is for
  typedef enum logic [1:0] {
    CTX_ALL,
    CTX_PRE,
    CTX_END
  } ctx_e;

  // Configuration as seen by the core
  typedef struct packed {
    mode_e             mode;
    logic [FILL_W-1:0] eff_len;
    logic              pass;
    logic [PAT_W-1:0]  pattern;
    logic              clear;
  } cfg_t;

endpackage

// File: design/byte_stream_pattern_remover_core.sv
// ----------------------------------------------------------------------------
// byte_stream_pattern_remover_core
// Removes a configured byte pattern (prefix, suffix or every occurrence)
// from a byte stream closed by an end-of-text item.
// ----------------------------------------------------------------------------
// A remove-all or open-prefix byte passes through accept, head check, compares of the window
// against the pattern, drops of a matched pattern and a head recheck. End of text emits each
// held byte, or one empty item if none is held; in suffix mode a compare and drop come first.
// Throughput: one item at a time, tready low until it is done; output stalls can hold it.
// Reset clears the window fill, prefix flag, removal count and output valid.
`include "assert_macros.svh"

module byte_stream_pattern_remover_core import bspr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] text_byte
  input  logic              s_axis_tuser_i,   // [0] opcode
  // output stream
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // [7:0] out_byte, [23:8] removed_count
  output logic              m_axis_tuser_o,   // [0] has_byte
  output logic              m_axis_tlast_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  bspr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer and window state
  state_e            state_q, state_d;
  ctx_e              ctx_q, ctx_d;
  logic              end_q, end_d;
  logic [7:0]        byte_q;
  logic [7:0]        win_q [PATTERN_MAX];
  logic [FILL_W-1:0] fill_q;
  logic              decided_q;
  logic [CNT_W-1:0]  removed_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [FILL_W-1:0] drop_cnt_q;

  // Output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_has_q;
  logic              out_last_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // Control
  logic              s_fire;
  logic              out_free;
  logic              fill_ge_len;
  logic              cmp_eq;
  logic              cmp_last;
  logic              append;
  logic [7:0]        append_byte;
  logic              pop;
  logic              push;
  logic              push_has;
  logic              push_last;
  logic              count_inc;
  logic              set_decided;
  logic              clr_decided;
  logic              cmp_clr;
  logic              cmp_inc;
  logic              drop_load;
  logic              drop_dec;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fill_ge_len     = (fill_q >= cfg.eff_len);

  // Shared byte comparator
  assign cmp_eq   = (win_q[cmp_idx_q] ==
                     cfg.pattern[{cmp_idx_q, 3'b000} +: 8]);
  assign cmp_last = (FILL_W'(cmp_idx_q) == cfg.eff_len - FILL_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    end_d   = end_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          end_d = s_axis_tuser_i;
          if (!s_axis_tuser_i) begin
            if (cfg.pass || (cfg.mode == MODE_PREFIX && decided_q)) begin
              state_d = S_EMIT;
            end else if (cfg.mode == MODE_ALL) begin
              state_d = S_HEAD;
              ctx_d   = CTX_ALL;
            end else if (cfg.mode == MODE_PREFIX) begin
              state_d = S_HEAD;
              ctx_d   = CTX_PRE;
            end else begin
              state_d = S_SUFFIX;
            end
          end else if (cfg.mode == MODE_SUFFIX && !cfg.pass && fill_q == cfg.eff_len) begin
            state_d = S_SCAN;
            ctx_d   = CTX_END;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_HEAD: begin
        state_d = fill_ge_len ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (!cmp_eq) begin
          state_d = (ctx_q == CTX_ALL) ? S_POP1 : S_EMIT;
        end else if (cmp_last) begin
          state_d = S_DROP;
        end
      end
      S_DROP: begin
        if (drop_cnt_q == FILL_W'(1)) begin
          state_d = (ctx_q == CTX_ALL) ? S_HEAD : S_EMIT;
        end
      end
      S_POP1: begin
        if (out_free) state_d = S_HEAD;
      end
      S_EMIT: begin
        if (fill_q == '0 && !end_q) begin
          state_d = S_IDLE;
        end else if (out_free && fill_q <= FILL_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_SUFFIX: begin
        if (!fill_ge_len) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    append      = 1'b0;
    append_byte = byte_q;
    pop         = 1'b0;
    push        = 1'b0;
    push_has    = 1'b1;
    push_last   = 1'b0;
    count_inc   = 1'b0;
    set_decided = 1'b0;
    clr_decided = 1'b0;
    cmp_clr     = 1'b0;
    cmp_inc     = 1'b0;
    drop_load   = 1'b0;
    drop_dec    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        append_byte = s_axis_tdata_i;
        if (s_fire) begin
          cmp_clr = 1'b1;
          if (!s_axis_tuser_i && (cfg.pass || cfg.mode != MODE_SUFFIX)) append = 1'b1;
        end
      end
      S_HEAD: begin
        cmp_clr = 1'b1;
      end
      S_SCAN: begin
        if (!cmp_eq) begin
          if (ctx_q == CTX_PRE) set_decided = 1'b1;
        end else if (cmp_last) begin
          count_inc = 1'b1;
          drop_load = 1'b1;
          if (ctx_q == CTX_PRE) set_decided = 1'b1;
        end else begin
          cmp_inc = 1'b1;
        end
      end
      S_DROP: begin
        pop      = 1'b1;
        drop_dec = 1'b1;
      end
      S_POP1: begin
        if (out_free) begin
          push = 1'b1;
          pop  = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free && (fill_q != '0 || end_q)) begin
          push      = 1'b1;
          push_has  = (fill_q != '0);
          push_last = end_q && (fill_q <= FILL_W'(1));
          pop       = (fill_q != '0);
          if (end_q && fill_q <= FILL_W'(1)) clr_decided = 1'b1;
        end
      end
      S_SUFFIX: begin
        if (fill_ge_len) begin
          if (out_free) begin
            push = 1'b1;
            pop  = 1'b1;
          end
        end else begin
          append = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ctx_q      <= CTX_ALL;
      end_q      <= 1'b0;
      fill_q     <= '0;
      decided_q  <= 1'b0;
      removed_q  <= '0;
      cmp_idx_q  <= '0;
      drop_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
      end_q   <= end_d;

      // window fill
      if (cfg.clear) begin
        fill_q <= '0;
      end else if (pop) begin
        fill_q <= fill_q - FILL_W'(1);
      end else if (append && 32'(fill_q) < PATTERN_MAX) begin
        fill_q <= fill_q + FILL_W'(1);
      end

      // prefix decision
      if (cfg.clear || clr_decided) begin
        decided_q <= 1'b0;
      end else if (set_decided) begin
        decided_q <= 1'b1;
      end

      // saturating removal count
      if (count_inc && removed_q != {CNT_W{1'b1}}) begin
        removed_q <= removed_q + CNT_W'(1);
      end

      // compare index
      if (cmp_clr) begin
        cmp_idx_q <= '0;
      end else if (cmp_inc) begin
        cmp_idx_q <= cmp_idx_q + IDX_W'(1);
      end

      // bytes left to drop
      if (drop_load) begin
        drop_cnt_q <= cfg.eff_len;
      end else if (drop_dec) begin
        drop_cnt_q <= drop_cnt_q - FILL_W'(1);
      end
    end
  end

  // Window bytes and latched input byte
  always_ff @(posedge clk_i) begin
    if (s_fire) byte_q <= s_axis_tdata_i;
    if (pop) begin
      for (int i = 0; i < PATTERN_MAX - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end else if (append && 32'(fill_q) < PATTERN_MAX) begin
      win_q[fill_q[IDX_W-1:0]] <= append_byte;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_byte_q <= push_has ? win_q[0] : 8'h00;
      out_has_q  <= push_has;
      out_last_q <= push_last;
      out_cnt_q  <= removed_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_byte_q};
  assign m_axis_tuser_o  = out_has_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  `BSPR_ASSERT_IMP(a_push_room, push, out_free, "push into a full output register")
  `BSPR_ASSERT_IMP(a_all_idle_fill,
                   state_q == S_IDLE && cfg.mode == MODE_ALL && !cfg.pass,
                   fill_q < cfg.eff_len, "all mode left a full window at idle")
  `BSPR_ASSERT_IMP(a_drop_cnt, state_q == S_DROP, drop_cnt_q != '0,
                   "drop state with no bytes to drop")
  `BSPR_ASSERT(a_count_mono, 1'b1 |=> removed_q >= $past(removed_q),
               "removal count went backwards")

endmodule

// File: design/bspr_cfg.sv
// ----------------------------------------------------------------------------
// bspr_cfg
// APB register block: mode, pattern length and pattern bytes. Any write
// raises a clear pulse that abandons the text in progress.
// ----------------------------------------------------------------------------
module bspr_cfg import bspr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  mode_e             mode_q;
  logic [LEN_W-1:0]  len_q;
  logic [63:0]       pat_lo_q;
  logic [63:0]       pat_hi_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ALL;
      len_q    <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   mode_q   <= mode_e'(pwdata[1:0]);
        REG_LEN:    len_q    <= pwdata[LEN_W-1:0];
        REG_PAT_LO: pat_lo_q <= pwdata[63:0];
        REG_PAT_HI: pat_hi_q <= pwdata[63:0];
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = APB_DW'(mode_q);
      REG_LEN:    prdata = APB_DW'(len_q);
      REG_PAT_LO: prdata = APB_DW'(pat_lo_q);
      REG_PAT_HI: prdata = APB_DW'(pat_hi_q);
      default:    prdata = '0;
    endcase
  end

  // Effective length clamps to the window depth
  always_comb begin
    cfg_o.mode    = mode_q;
    cfg_o.eff_len = (32'(len_q) > PATTERN_MAX) ? FILL_W'(PATTERN_MAX) : FILL_W'(len_q);
    cfg_o.pass    = (len_q == '0) || (mode_q == MODE_PASS);
    cfg_o.pattern = {pat_hi_q, pat_lo_q};
    cfg_o.clear   = wr_en;
  end

endmodule

// File: tb/byte_stream_pattern_remover_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_pattern_remover_core_tb
// Self-checking bench for the pattern remover. It checks register
// read-back after reset and after every write. A short scripted run covers
// pass-through, remove-all, prefix, suffix and the unused mode. Random
// phases follow, each with its own mode, length and pattern, and send texts
// built mostly from pieces of the pattern. Every output transfer is
// compared with a local model of the window and the removal counter.
// ----------------------------------------------------------------------------
module byte_stream_pattern_remover_core_tb;
  import bspr_pkg::*;

  localparam logic        OP_TEXT       = 1'b0;
  localparam logic        OP_EOT        = 1'b1;
  localparam int unsigned RANDOM_ITEMS  = 220;
  localparam int unsigned QUIET_ITEMS   = 170;
  localparam int unsigned SETTLE_CYCLES = 4 * PATTERN_MAX;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // One output transfer
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last;
    logic [15:0] removed_count;
  } kept_item_t;

  // Scripted run rows
  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_EOT,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [63:0] val;
    logic        fixed;
    kept_item_t  want;
  } script_row_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i  = '0;
  logic              s_axis_tuser_i  = OP_TEXT;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [23:0]       m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              m_axis_tlast_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [APB_AW-1:0] paddr           = '0;
  logic [APB_DW-1:0] pwdata          = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  byte_stream_pattern_remover_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state: configuration, held window, counter
  mode_e       cur_mode    = MODE_ALL;
  logic [4:0]  pat_len     = '0;
  logic [63:0] pat_lo      = '0;
  logic [63:0] pat_hi      = '0;
  logic [7:0]  held [PATTERN_MAX];
  int unsigned held_cnt    = 0;
  bit          prefix_seen = 1'b0;
  logic [15:0] removed     = '0;

  kept_item_t  kept_q [$];
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned stall_left  = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;
  int unsigned items_sent  = 0;
  script_row_t directed_rows [30];

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // ---------------- pattern removal model ----------------
  function automatic logic [7:0] pattern_byte(int unsigned i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic bit head_matches(int unsigned n);
    if (n == 0 || n > held_cnt) return 1'b0;
    for (int unsigned i = 0; i < n; i++)
      if (held[i] != pattern_byte(i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void drop_head(int unsigned k);
    if (k >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int unsigned i = 0; i < held_cnt - k; i++) held[i] = held[i+k];
      held_cnt -= k;
    end
  endfunction

  function automatic void keep(logic [7:0] b, logic has);
    kept_item_t it;
    it = '{b, has, 1'b0, removed};
    kept_q.push_back(it);
  endfunction

  function automatic void count_hit();
    if (removed != 16'hFFFF) removed++;
  endfunction

  function automatic void flush_held();
    for (int unsigned i = 0; i < held_cnt; i++) keep(held[i], 1'b1);
    held_cnt = 0;
  endfunction

  function automatic void hold(logic [7:0] b);
    if (held_cnt < PATTERN_MAX) begin
      held[held_cnt] = b;
      held_cnt++;
    end
  endfunction

  // Expected output transfers caused by one accepted input transfer
  function automatic void remove_pattern(logic op, logic [7:0] b);
    int unsigned n;
    bit          thru;
    int unsigned start;
    n     = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    thru  = (n == 0) || (cur_mode == MODE_PASS);
    start = kept_q.size();
    if (op == OP_TEXT) begin
      if (thru || (cur_mode == MODE_PREFIX && prefix_seen)) begin
        flush_held();
        keep(b, 1'b1);
      end else if (cur_mode == MODE_ALL) begin
        hold(b);
        // leftmost scan, bytes leave once they cannot start a match
        while (held_cnt >= n) begin
          if (head_matches(n)) begin
            drop_head(n);
            count_hit();
          end else begin
            keep(held[0], 1'b1);
            drop_head(1);
          end
        end
      end else if (cur_mode == MODE_PREFIX) begin
        hold(b);
        if (held_cnt >= n) begin
          if (head_matches(n)) begin
            drop_head(n);
            count_hit();
          end
          prefix_seen = 1'b1;
          flush_held();
        end
      end else begin
        // suffix: keep only the last n-1 bytes before adding this one
        while (held_cnt >= n && held_cnt > 0) begin
          keep(held[0], 1'b1);
          drop_head(1);
        end
        hold(b);
      end
    end else begin
      if (cur_mode == MODE_SUFFIX && !thru && held_cnt == n && head_matches(n)) begin
        drop_head(n);
        count_hit();
      end
      flush_held();
      if (kept_q.size() == start) keep(8'h00, 1'b0);
      kept_q[kept_q.size()-1].last = 1'b1;
      held_cnt    = 0;
      prefix_seen = 1'b0;
    end
  endfunction

  // ---------------- register port ----------------
  task automatic reg_access(input logic wr, input reg_idx_e idx, input logic [63:0] wval,
                            output logic [63:0] rval);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wval;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rval = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [63:0] v);
    logic [63:0] rd;
    reg_access(1'b1, idx, v, rd);
    case (idx)
      REG_MODE:   cur_mode = mode_e'(v[1:0]);
      REG_LEN:    pat_len  = v[4:0];
      REG_PAT_LO: pat_lo   = v;
      default:    pat_hi   = v;
    endcase
    // any write drops the text in progress
    held_cnt    = 0;
    prefix_seen = 1'b0;
    reg_access(1'b0, idx, '0, rd);
    check_field("register read-back", v, rd);
  endtask

  // ---------------- input side ----------------
  task automatic push_item(input logic op, input logic [7:0] b, input logic fixed,
                           input kept_item_t want);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    remove_pattern(op, b);
    if (fixed) kept_q[kept_q.size()-1] = want;
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Idle the input, let every expected transfer out, then let the core settle
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (kept_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One configuration and one or two texts built from pieces of its pattern
  task automatic run_phase(input int unsigned ph);
    mode_e       md;
    logic [4:0]  ln;
    logic [7:0]  al [2];
    logic [7:0]  pat [16];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  txt [$];
    int unsigned n;
    int unsigned texts;
    int unsigned tlen;
    int unsigned r;
    int unsigned cnt;
    bit          cut;
    if (items_sent >= QUIET_ITEMS) begin
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
    end else begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
    end
    if (ph % 5 == 0) begin
      al[0] = 8'h00;
      al[1] = 8'hFF;
    end else begin
      al[0] = 8'($urandom_range(0, 255));
      al[1] = 8'($urandom_range(0, 255));
    end
    if (ph < 4) md = mode_e'(2'(ph));
    else if ($urandom_range(0, 9) == 0) md = MODE_PASS;
    else md = mode_e'(2'($urandom_range(0, 2)));
    case (ph)
      4:       ln = 5'd1;
      5:       ln = 5'd16;
      6:       ln = 5'd31;
      7:       ln = 5'd0;
      default: ln = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(9, 16))
                                                 : 5'($urandom_range(1, 8));
    endcase
    for (int unsigned k = 0; k < 16; k++) begin
      pat[k] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                          : al[$urandom_range(0, 1)];
      if (k < 8) lo[8*k +: 8] = pat[k];
      else hi[8*(k-8) +: 8] = pat[k];
    end
    quiesce();
    set_reg(REG_MODE, 64'(md));
    set_reg(REG_LEN, 64'(ln));
    set_reg(REG_PAT_LO, lo);
    set_reg(REG_PAT_HI, hi);
    n     = (ln > PATTERN_MAX) ? PATTERN_MAX : ln;
    texts = $urandom_range(1, 2);
    for (int unsigned t = 0; t < texts; t++) begin
      txt.delete();
      tlen = $urandom_range(0, 2 * n + 6);
      while (txt.size() < tlen) begin
        r = $urandom_range(0, 9);
        if (r < 5 && n != 0) begin
          cnt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : n;
          for (int unsigned j = 0; j < cnt; j++) txt.push_back(pat[j]);
        end else if (r < 8) begin
          txt.push_back(al[$urandom_range(0, 1)]);
        end else begin
          txt.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (txt[j]) begin
        push_item(OP_TEXT, txt[j], 1'b0, '0);
        maybe_gap();
        items_sent++;
      end
      // now and then the last text is left open and dropped by the next write
      cut = (t == texts - 1) && ($urandom_range(0, 3) == 0);
      if (!cut) begin
        push_item(OP_EOT, 8'($urandom_range(0, 255)), 1'b0, '0);
        maybe_gap();
        items_sent++;
      end
    end
  endtask

  // ---------------- output side ----------------
  // Ready with random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(1, 11);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin : watch_output
    kept_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (kept_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: expected none, actual data %h user %b last %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = kept_q.pop_front();
        check_field("out_byte", 64'(want.out_byte), 64'(m_axis_tdata_o[7:0]));
        check_field("has_byte", 64'(want.has_byte), 64'(m_axis_tuser_o));
        check_field("last", 64'(want.last), 64'(m_axis_tlast_o));
        check_field("removed_count", 64'(want.removed_count), 64'(m_axis_tdata_o[23:8]));
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("byte_stream_pattern_remover_core regression: fail");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    logic [63:0] rd;
    logic [63:0] reset_val [4];
    int unsigned ph;
    reset_val = '{64'd2, 64'd0, 64'd0, 64'd0};
    // scripted run: pass-through after reset, then each mode on "abc"
    directed_rows = '{
      '{ROW_BYTE, REG_MODE,   64'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 16'd0}},
      '{ROW_BYTE, REG_MODE,   64'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 16'd0}},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
      '{ROW_REG,  REG_PAT_LO, 64'h636261, 1'b0, '0},
      '{ROW_REG,  REG_LEN,    64'd3, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h78, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h62, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h63, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h62, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h63, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b0, '0},
      '{ROW_REG,  REG_MODE,   64'(MODE_PREFIX), 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h62, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h63, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h64, 1'b0, '0},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b0, '0},
      '{ROW_REG,  REG_MODE,   64'(MODE_SUFFIX), 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h62, 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h63, 1'b0, '0},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b0, '0},
      '{ROW_REG,  REG_MODE,   64'(MODE_PASS), 1'b0, '0},
      '{ROW_BYTE, REG_MODE,   64'h61, 1'b0, '0},
      '{ROW_EOT,  REG_MODE,   64'h00, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values after reset
    for (int unsigned i = 0; i < 4; i++) begin
      reg_access(1'b0, reg_idx_e'(2'(i)), '0, rd);
      check_field("register after reset", reset_val[i], rd);
    end

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        quiesce();
        set_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        push_item((directed_rows[i].kind == ROW_EOT) ? OP_EOT : OP_TEXT,
                  directed_rows[i].val[7:0], directed_rows[i].fixed, directed_rows[i].want);
        maybe_gap();
      end
    end

    // random phases
    ph = 0;
    while (items_sent < RANDOM_ITEMS || ph < 10) begin
      run_phase(ph);
      ph++;
    end

    // drain
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (kept_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("byte_stream_pattern_remover_core regression: pass");
    end else begin
      $display("byte_stream_pattern_remover_core regression: fail");
    end
    $finish;
  end

endmodule
